/* src/playfair_digraph_encrypt_core_defines.svh */
// assertion macros for the playfair digraph encrypt core
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfe check failed");

// next-cycle implication, checked outside reset
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfe check failed");

`endif

/* src/pfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types, constants and letter/cell helpers of the playfair core
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int LETTER_BITS     = 5;
  localparam int CELL_BITS       = 5;
  localparam int RC_BITS         = 3;
  localparam int SIDE            = 5;
  localparam int CELLS           = 25;
  localparam int LETTERS         = 26;
  localparam int KEY_REG_BITS    = 60;
  localparam int KEY_BITS        = 3 * KEY_REG_BITS;
  localparam int KEY_LEN_BITS    = 6;
  localparam int REG_INDEX_BITS  = 3;
  localparam int MAX_KEY_LETTERS = 36;

  localparam logic [LETTER_BITS-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_BITS-1:0] LETTER_J = 5'd9;
  localparam logic [LETTER_BITS-1:0] LETTER_Z = 5'd25;

  localparam logic [REG_INDEX_BITS-1:0] REG_KEY_LOW  = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_KEY_MID  = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_KEY_HIGH = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_KEY_LEN  = 3'd3;

  typedef logic [LETTER_BITS-1:0] letter_t;
  typedef logic [CELL_BITS-1:0]   cell_t;
  typedef logic [RC_BITS-1:0]     rc_t;

  typedef struct packed {
    letter_t first_letter;
    letter_t second_letter;
  } in_t;

  typedef struct packed {
    letter_t first_cipher;
    letter_t second_cipher;
    logic    pair_error;
  } out_t;

  // one square write, broadcast from the builder to every lane
  typedef struct packed {
    logic    wr;
    letter_t letter;
    cell_t   pos;
  } sq_wr_t;

  // clamp to z, fold j into i
  function automatic letter_t fold_letter(letter_t code);
    letter_t c;
    c = (code > LETTER_Z) ? LETTER_Z : code;
    if (c == LETTER_J) begin
      c = LETTER_I;
    end
    return c;
  endfunction

  function automatic rc_t cell_row(cell_t pos);
    rc_t r;
    if (pos >= 5'd20) r = 3'd4;
    else if (pos >= 5'd15) r = 3'd3;
    else if (pos >= 5'd10) r = 3'd2;
    else if (pos >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic cell_t make_cell(rc_t row, rc_t col);
    return 5'({2'b00, row}) * 5'(SIDE) + 5'({2'b00, col});
  endfunction

  function automatic rc_t cell_col(cell_t pos);
    cell_t base;
    base = make_cell(cell_row(pos), 3'd0);
    return 3'(pos - base);
  endfunction

  // step right or down with wrap
  function automatic rc_t wrap_inc(rc_t v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
  endfunction

endpackage

/* src/pfe_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_builder
// walks the key letters then the alphabet, one per cycle, filling the square
// ----------------------------------------------------------------------------
module pfe_builder #(
  parameter int MAX_KEY_LETTERS = pfe_pkg::MAX_KEY_LETTERS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic [pfe_pkg::KEY_BITS-1:0]        key_vec,
  input  logic [pfe_pkg::KEY_LEN_BITS-1:0]    key_length,
  output logic                                busy,
  output pfe_pkg::sq_wr_t                     sq_wr
);

  localparam int STEPS = MAX_KEY_LETTERS + pfe_pkg::LETTERS;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int KW    = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
  localparam int CW    = (SW > pfe_pkg::KEY_LEN_BITS) ? SW : pfe_pkg::KEY_LEN_BITS;

  logic [SW-1:0]                   step;
  logic [pfe_pkg::CELL_BITS-1:0]   fill;
  logic [pfe_pkg::LETTERS-1:0]     used;

  logic [pfe_pkg::KEY_LEN_BITS-1:0] count;
  logic                             is_key;
  logic [KW-1:0]                    kidx;
  pfe_pkg::letter_t                 raw;
  pfe_pkg::letter_t                 cand;
  logic                             usable;
  logic                             take;

  always_comb begin
    count  = (key_length > pfe_pkg::KEY_LEN_BITS'(MAX_KEY_LETTERS))
             ? pfe_pkg::KEY_LEN_BITS'(MAX_KEY_LETTERS) : key_length;
    is_key = (step < SW'(MAX_KEY_LETTERS));
    kidx   = is_key ? step[KW-1:0] : '0;
    if (is_key) begin
      raw    = key_vec[pfe_pkg::LETTER_BITS * kidx +: pfe_pkg::LETTER_BITS];
      usable = (CW'(step) < CW'(count)) && (raw <= pfe_pkg::LETTER_Z);
      cand   = (raw == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : raw;
    end else begin
      raw    = pfe_pkg::LETTER_BITS'(step - SW'(MAX_KEY_LETTERS));
      usable = (raw != pfe_pkg::LETTER_J);
      cand   = raw;
    end
    take = busy && usable && !used[cand] && (fill < pfe_pkg::CELL_BITS'(pfe_pkg::CELLS));
    sq_wr.wr     = take;
    sq_wr.letter = cand;
    sq_wr.pos    = fill;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      step <= '0;
      fill <= '0;
      used <= '0;
    end else if (busy) begin
      if (take) begin
        used[cand] <= 1'b1;
        fill       <= fill + 1'b1;
      end
      if (step == SW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

endmodule

/* src/pfe_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_lane
// one letter lane: own copies of the letter-to-cell and cell-to-letter maps
// ----------------------------------------------------------------------------
module pfe_lane (
  input  logic              clk,
  input  pfe_pkg::sq_wr_t   sq_wr,
  input  logic              en_look,
  input  pfe_pkg::letter_t  letter,
  output pfe_pkg::cell_t    pos,
  input  logic              en_sub,
  input  pfe_pkg::cell_t    target,
  output pfe_pkg::letter_t  cipher
);

  pfe_pkg::cell_t   where_mem  [0:pfe_pkg::LETTERS-1];
  pfe_pkg::letter_t square_mem [0:pfe_pkg::CELLS-1];

  always_ff @(posedge clk) begin
    if (sq_wr.wr) begin
      where_mem[sq_wr.letter] <= sq_wr.pos;
      square_mem[sq_wr.pos]   <= sq_wr.letter;
    end
  end

  // cell lookup of the folded letter
  always_ff @(posedge clk) begin
    if (en_look) begin
      pos <= where_mem[pfe_pkg::fold_letter(letter)];
    end
  end

  // substitution read
  always_ff @(posedge clk) begin
    if (en_sub) begin
      cipher <= square_mem[target];
    end
  end

endmodule

/* src/pfe_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_merge
// combines both lane cells into the two substitution cells
// ----------------------------------------------------------------------------
module pfe_merge (
  input  pfe_pkg::cell_t cell_a,
  input  pfe_pkg::cell_t cell_b,
  output pfe_pkg::cell_t target_a,
  output pfe_pkg::cell_t target_b
);

  pfe_pkg::rc_t r1, c1, r2, c2;

  always_comb begin
    r1 = pfe_pkg::cell_row(cell_a);
    c1 = pfe_pkg::cell_col(cell_a);
    r2 = pfe_pkg::cell_row(cell_b);
    c2 = pfe_pkg::cell_col(cell_b);
    if (r1 == r2) begin
      // same row, also covers identical letters
      target_a = pfe_pkg::make_cell(r1, pfe_pkg::wrap_inc(c1));
      target_b = pfe_pkg::make_cell(r2, pfe_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      target_a = pfe_pkg::make_cell(pfe_pkg::wrap_inc(r1), c1);
      target_b = pfe_pkg::make_cell(pfe_pkg::wrap_inc(r2), c2);
    end else begin
      target_a = pfe_pkg::make_cell(r1, c2);
      target_b = pfe_pkg::make_cell(r2, c1);
    end
  end

endmodule

/* src/playfair_digraph_encrypt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_core
// playfair encryption of one digraph per request over a keyed 5x5 square
// ----------------------------------------------------------------------------
// usage:
//   in channel  : in_valid / in_stall / in_data, one plaintext digraph a request
//   out channel : out_valid / out_stall / out_data, cipher digraph and error flag
//   config      : wr_en / wr_index / wr_data, write-only key registers
//   after reset, and after every config write, the square is rebuilt by a
//   sequencer that visits each key slot and then each alphabet letter, one a
//   cycle; in_stall is high then
//   from request to result a request passes the cell lookup, the substitution
//   read and the output register
//   throughput one request per cycle unless building or out_stall, set by the
//   two lanes' own map copies so both letters are looked up in the same cycle
//   each pipeline stage moves when the one after it is empty or moving, so
//   while the receiver stalls the core still takes requests into empty
//   stages; the held result stays on out_data unchanged
//   reset is synchronous and clears the pipeline valids
// ----------------------------------------------------------------------------
`include "playfair_digraph_encrypt_core_defines.svh"

module playfair_digraph_encrypt_core #(
  parameter int MAX_KEY_LETTERS = pfe_pkg::MAX_KEY_LETTERS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pfe_pkg::in_t                          in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pfe_pkg::out_t                         out_data,
  input  logic                                  wr_en,
  input  logic [pfe_pkg::REG_INDEX_BITS-1:0]    wr_index,
  input  logic [pfe_pkg::KEY_REG_BITS-1:0]      wr_data
);

  // key registers
  logic [pfe_pkg::KEY_REG_BITS-1:0] key_low;
  logic [pfe_pkg::KEY_REG_BITS-1:0] key_mid;
  logic [pfe_pkg::KEY_REG_BITS-1:0] key_high;
  logic [pfe_pkg::KEY_LEN_BITS-1:0] key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_mid    <= '0;
      key_high   <= '0;
      key_length <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pfe_pkg::REG_KEY_LOW:  key_low    <= wr_data;
        pfe_pkg::REG_KEY_MID:  key_mid    <= wr_data;
        pfe_pkg::REG_KEY_HIGH: key_high   <= wr_data;
        pfe_pkg::REG_KEY_LEN:  key_length <= wr_data[pfe_pkg::KEY_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // square builder, restarted by any config write
  logic            building;
  pfe_pkg::sq_wr_t sq_wr;

  pfe_builder #(
    .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
  ) u_builder (
    .clk       (clk),
    .rst       (rst),
    .restart   (wr_en),
    .key_vec   ({key_high, key_mid, key_low}),
    .key_length(key_length),
    .busy      (building),
    .sq_wr     (sq_wr)
  );

  // pipeline control
  logic v1, v2;
  logic e1, e2;
  logic en1, en2, en3;
  logic in_take;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = building || !en1;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_take;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  // error flag travels beside the lanes
  always_ff @(posedge clk) begin
    if (en1) begin
      e1 <= (pfe_pkg::fold_letter(in_data.first_letter) ==
             pfe_pkg::fold_letter(in_data.second_letter));
    end
    if (en2) begin
      e2 <= e1;
    end
  end

  // two letter lanes and the merge between their stages
  pfe_pkg::cell_t   cell_a, cell_b;
  pfe_pkg::cell_t   target_a, target_b;
  pfe_pkg::letter_t cipher_a, cipher_b;

  pfe_lane u_lane_a (
    .clk    (clk),
    .sq_wr  (sq_wr),
    .en_look(en1),
    .letter (in_data.first_letter),
    .pos    (cell_a),
    .en_sub (en2),
    .target (target_a),
    .cipher (cipher_a)
  );

  pfe_lane u_lane_b (
    .clk    (clk),
    .sq_wr  (sq_wr),
    .en_look(en1),
    .letter (in_data.second_letter),
    .pos    (cell_b),
    .en_sub (en2),
    .target (target_b),
    .cipher (cipher_b)
  );

  pfe_merge u_merge (
    .cell_a  (cell_a),
    .cell_b  (cell_b),
    .target_a(target_a),
    .target_b(target_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en3) begin
      out_data.first_cipher  <= cipher_a;
      out_data.second_cipher <= cipher_b;
      out_data.pair_error    <= e2;
    end
  end

  // checks
  `PFE_ASSERT_SAME(a_no_j_out, clk, rst, out_valid, (out_data.first_cipher != pfe_pkg::LETTER_J) && (out_data.second_cipher != pfe_pkg::LETTER_J))
  `PFE_ASSERT_SAME(a_err_equal, clk, rst, out_valid && out_data.pair_error, out_data.first_cipher == out_data.second_cipher)
  `PFE_ASSERT_NEXT(a_write_rebuilds, clk, rst, wr_en, building && in_stall)

endmodule
